// ----- rtl/core/raq_pkg.sv -----
`default_nettype none
package raq_pkg;

	localparam int DATA_W = 32;
	localparam int EPS_W  = 31;

	typedef logic signed [DATA_W-1:0] fx_t;
	typedef logic [EPS_W-1:0] eps_t;

	typedef struct packed {
		fx_t u_x;
		fx_t u_y;
		fx_t u_z;
		fx_t w_x;
		fx_t w_y;
		fx_t w_z;
	} axes_t;

	typedef struct packed {
		fx_t q_w;
		fx_t q_x;
		fx_t q_y;
		fx_t q_z;
		logic [1:0] case_taken;
	} quat_t;

	typedef enum logic [1:0] {
		CASE_TRACE = 2'd0,
		CASE_M00   = 2'd1,
		CASE_M11   = 2'd2,
		CASE_M22   = 2'd3
	} case_t;

endpackage
`default_nettype wire

// ----- rtl/core/raq_if.sv -----
`default_nettype none
interface raq_axes_if import raq_pkg::*; ();
	logic valid;
	logic ready;
	axes_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface raq_quat_if import raq_pkg::*; ();
	logic valid;
	logic ready;
	quat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface raq_cfg_if import raq_pkg::*; ();
	logic valid;
	logic ready;
	eps_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/raq_front.sv -----
`default_nettype none
module raq_front import raq_pkg::*; #(
	parameter int FRAC_BITS = 30
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  axes_t in_data,
	input  eps_t eps,
	output logic out_vld,
	output logic [FRAC_BITS+2:0] radicand,
	output case_t kase,
	output logic [2:0] neg,
	output logic [2:0][FRAC_BITS+2:0] mag
);

	localparam int RW  = FRAC_BITS + 3;
	localparam int PRW = 64 - FRAC_BITS;
	localparam int MW  = PRW + 1;
	localparam int AW  = MW + 2;
	localparam logic signed [AW-1:0] ONE_A = AW'(longint'(1) << FRAC_BITS);
	localparam logic signed [AW-1:0] R_MIN = AW'(1);
	localparam logic signed [AW-1:0] R_MAX = AW'(longint'(4) << FRAC_BITS);

	// stage 1: cross product terms
	logic signed [63:0] p_s1 [6];
	axes_t a_s1;
	logic vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= in_data.w_y * in_data.u_z;
			p_s1[1] <= in_data.w_z * in_data.u_y;
			p_s1[2] <= in_data.w_z * in_data.u_x;
			p_s1[3] <= in_data.w_x * in_data.u_z;
			p_s1[4] <= in_data.w_x * in_data.u_y;
			p_s1[5] <= in_data.w_y * in_data.u_x;
			a_s1 <= in_data;
		end
	end

	// stage 2: floor shift and subtract into column 0
	logic signed [PRW-1:0] f_c [6];
	logic signed [MW-1:0] m00_s2, m10_s2, m20_s2;
	axes_t a_s2;
	logic vld_s2;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			f_c[i] = PRW'(p_s1[i] >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m00_s2 <= MW'(f_c[0]) - MW'(f_c[1]);
			m10_s2 <= MW'(f_c[2]) - MW'(f_c[3]);
			m20_s2 <= MW'(f_c[4]) - MW'(f_c[5]);
			a_s2 <= a_s1;
		end
	end

	// stage 3: trace, radicands, numerators, diagonal compares
	logic signed [AW-1:0] e00, e10, e20, ewx, ewy, ewz, eux, euy, euz;
	logic signed [AW-1:0] t_c;
	logic signed [AW-1:0] rt_s3, ra_s3, rb_s3, rc_s3;
	logic signed [AW-1:0] n_s3 [6];
	logic trace_s3, c1_s3, c2_s3, c3_s3, vld_s3;

	always_comb begin
		e00 = AW'(m00_s2);
		e10 = AW'(m10_s2);
		e20 = AW'(m20_s2);
		ewx = AW'(a_s2.w_x);
		ewy = AW'(a_s2.w_y);
		ewz = AW'(a_s2.w_z);
		eux = AW'(a_s2.u_x);
		euy = AW'(a_s2.u_y);
		euz = AW'(a_s2.u_z);
		t_c = ONE_A + e00 + ewy + euz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s3 <= t_c;
			ra_s3 <= ONE_A + e00 - ewy - euz;
			rb_s3 <= ONE_A + ewy - e00 - euz;
			rc_s3 <= ONE_A + euz - e00 - ewy;
			trace_s3 <= t_c > $signed(AW'(eps));
			c1_s3 <= e00 > ewy;
			c2_s3 <= e00 > euz;
			c3_s3 <= ewy > euz;
			n_s3[0] <= ewz - euy;
			n_s3[1] <= eux - e20;
			n_s3[2] <= e10 - ewx;
			n_s3[3] <= e10 + ewx;
			n_s3[4] <= eux + e20;
			n_s3[5] <= ewz + euy;
		end
	end

	// stage 4: pick the path, clamp radicand and numerators
	case_t kase_c;
	logic signed [AW-1:0] r_c, rcl_c;
	logic signed [AW-1:0] l_c [3];
	logic signed [AW-1:0] abs_c [3];
	logic [2:0] neg_c;
	logic [2:0][RW-1:0] mag_c;

	always_comb begin
		priority if (trace_s3) begin
			kase_c = CASE_TRACE;
			r_c = rt_s3;
			l_c[0] = n_s3[0];
			l_c[1] = n_s3[1];
			l_c[2] = n_s3[2];
		end else if (c1_s3 && c2_s3) begin
			kase_c = CASE_M00;
			r_c = ra_s3;
			l_c[0] = n_s3[0];
			l_c[1] = n_s3[3];
			l_c[2] = n_s3[4];
		end else if (c3_s3) begin
			kase_c = CASE_M11;
			r_c = rb_s3;
			l_c[0] = n_s3[1];
			l_c[1] = n_s3[3];
			l_c[2] = n_s3[5];
		end else begin
			kase_c = CASE_M22;
			r_c = rc_s3;
			l_c[0] = n_s3[2];
			l_c[1] = n_s3[4];
			l_c[2] = n_s3[5];
		end
		if (r_c < R_MIN) begin
			rcl_c = R_MIN;
		end else if (r_c > R_MAX) begin
			rcl_c = R_MAX;
		end else begin
			rcl_c = r_c;
		end
		for (int j = 0; j < 3; j++) begin
			neg_c[j] = l_c[j][AW-1];
			abs_c[j] = neg_c[j] ? -l_c[j] : l_c[j];
			mag_c[j] = RW'((abs_c[j] > R_MAX) ? R_MAX : abs_c[j]);
		end
	end

	logic [RW-1:0] rad_s4;
	case_t kase_s4;
	logic [2:0] neg_s4;
	logic [2:0][RW-1:0] mag_s4;
	logic vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4 <= RW'(rcl_c);
			kase_s4 <= kase_c;
			neg_s4 <= neg_c;
			mag_s4 <= mag_c;
		end
	end

	assign out_vld  = vld_s4;
	assign radicand = rad_s4;
	assign kase     = kase_s4;
	assign neg      = neg_s4;
	assign mag      = mag_s4;

endmodule
`default_nettype wire

// ----- rtl/core/raq_sqrt.sv -----
`default_nettype none
module raq_sqrt import raq_pkg::*; #(
	parameter int FRAC_BITS = 30,
	parameter int SIDE_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [FRAC_BITS+2:0] rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic out_vld,
	output logic [FRAC_BITS+1:0] root,
	output logic [SIDE_W-1:0] out_side
);

	localparam int QW = FRAC_BITS + 2;
	localparam int XW = 2 * FRAC_BITS + 3;
	localparam int TW = XW + 1;

	logic [TW-1:0] rem_s [QW];
	logic [QW-1:0] root_s [QW];
	logic [SIDE_W-1:0] side_s [QW];
	logic vld_s [QW];

	// one root bit per stage, msb first; rem holds x - root^2
	for (genvar i = 0; i < QW; i++) begin : g_stg
		localparam int K = QW - 1 - i;
		logic [TW-1:0] rem_in, trial;
		logic [QW-1:0] root_in;
		logic [SIDE_W-1:0] side_in;
		logic vld_in;

		if (i == 0) begin : g_first
			assign rem_in  = TW'(rad) << FRAC_BITS;
			assign root_in = '0;
			assign side_in = in_side;
			assign vld_in  = in_vld;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign side_in = side_s[i-1];
			assign vld_in  = vld_s[i-1];
		end

		// (root + 2^k)^2 - root^2
		assign trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[i]  <= rem_in - trial;
					root_s[i] <= root_in | (QW'(1) << K);
				end else begin
					rem_s[i]  <= rem_in;
					root_s[i] <= root_in;
				end
				side_s[i] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign root     = root_s[QW-1];
	assign out_side = side_s[QW-1];

endmodule
`default_nettype wire

// ----- rtl/core/raq_div.sv -----
`default_nettype none
module raq_div import raq_pkg::*; #(
	parameter int FRAC_BITS = 30,
	parameter int SIDE_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [FRAC_BITS+2:0] divisor,
	input  logic [2:0] in_neg,
	input  logic [2:0][FRAC_BITS+2:0] in_mag,
	input  logic [SIDE_W-1:0] in_side,
	output logic out_vld,
	output logic [2:0] out_neg,
	output logic [2:0][FRAC_BITS:0] quot,
	output logic [SIDE_W-1:0] out_side
);

	localparam int DW = FRAC_BITS + 3;
	localparam int PW = FRAC_BITS + 4;
	localparam int NS = FRAC_BITS + 1;
	localparam logic [NS-1:0] ONE_Q = NS'(1) << FRAC_BITS;

	logic [PW-1:0] p_s [NS][3];
	logic [NS-1:0] q_s [NS][3];
	logic sat_s [NS][3];
	logic [2:0] neg_s [NS];
	logic [DW-1:0] d_s [NS];
	logic [SIDE_W-1:0] side_s [NS];
	logic vld_s [NS];

	// restoring division, one quotient bit per stage; a numerator of at least
	// twice the divisor saturates, so the partial remainder stays below 2*d
	for (genvar i = 0; i < NS; i++) begin : g_stg
		logic [DW-1:0] d_in;
		logic [2:0] neg_in;
		logic [SIDE_W-1:0] side_in;
		logic vld_in;

		if (i == 0) begin : g_first
			assign d_in    = divisor;
			assign neg_in  = in_neg;
			assign side_in = in_side;
			assign vld_in  = in_vld;
		end else begin : g_next
			assign d_in    = d_s[i-1];
			assign neg_in  = neg_s[i-1];
			assign side_in = side_s[i-1];
			assign vld_in  = vld_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[i]    <= d_in;
				neg_s[i]  <= neg_in;
				side_s[i] <= side_in;
			end
		end

		for (genvar j = 0; j < 3; j++) begin : g_lane
			logic [PW-1:0] p_in;
			logic [NS-1:0] q_in;
			logic sat_in, qbit;

			if (i == 0) begin : g_first
				assign p_in   = PW'(in_mag[j]);
				assign q_in   = '0;
				assign sat_in = PW'(in_mag[j]) >= (PW'(divisor) << 1);
			end else begin : g_next
				assign p_in   = p_s[i-1][j] << 1;
				assign q_in   = q_s[i-1][j];
				assign sat_in = sat_s[i-1][j];
			end

			assign qbit = p_in >= PW'(d_in);

			always_ff @(posedge clk) begin
				if (en) begin
					p_s[i][j]   <= qbit ? p_in - PW'(d_in) : p_in;
					q_s[i][j]   <= (q_in << 1) | NS'(qbit);
					sat_s[i][j] <= sat_in;
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			quot[j] = (sat_s[NS-1][j] || q_s[NS-1][j] > ONE_Q) ? ONE_Q : q_s[NS-1][j];
		end
	end

	assign out_vld  = vld_s[NS-1];
	assign out_neg  = neg_s[NS-1];
	assign out_side = side_s[NS-1];

endmodule
`default_nettype wire

// ----- rtl/core/rotation_axes_to_quaternion.sv -----
// channel  dir  payload                               beat when
// axes     in   u_x u_y u_z w_x w_y w_z (Q2.30)       valid && ready
// quat     out  q_w q_x q_y q_z (Q2.30), case_taken   valid && ready
// cfg      in   trace_epsilon (31 bits)               valid && ready (ready held high)
//
// one beat per cycle sustained while quat.ready stays high; pipeline stages:
// 4 matrix/select stages, FRAC_BITS+2 root stages, FRAC_BITS+1 divide stages, output reg.
// reset clears all valid bits and sets trace_epsilon to about 1e-6.
// a two-entry output buffer takes the last stage; the pipeline freezes only while
// its spare entry is full, so axes.ready is a register output.
`default_nettype none
module rotation_axes_to_quaternion import raq_pkg::*; #(
	parameter int FRAC_BITS = 30
) (
	input  logic clk,
	input  logic arst_n,
	raq_axes_if.sink axes,
	raq_quat_if.source quat,
	raq_cfg_if.sink cfg
);

	localparam int RW = FRAC_BITS + 3;
	localparam int QW = FRAC_BITS + 2;
	localparam int SIDE1_W = 5 + 3 * RW;
	localparam int SIDE2_W = QW + 2;
	localparam eps_t EPS_RESET = EPS_W'(1074 >> (30 - FRAC_BITS));
	localparam logic signed [DATA_W-1:0] ONE_32 = DATA_W'(longint'(1) << FRAC_BITS);

	logic en;
	eps_t eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg.valid) begin
			eps_q <= cfg.data;
		end
	end

	assign cfg.ready = 1'b1;

	// front end
	logic fr_vld;
	logic [RW-1:0] fr_rad;
	case_t fr_kase;
	logic [2:0] fr_neg;
	logic [2:0][RW-1:0] fr_mag;

	raq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (axes.valid),
		.in_data  (axes.data),
		.eps      (eps_q),
		.out_vld  (fr_vld),
		.radicand (fr_rad),
		.kase     (fr_kase),
		.neg      (fr_neg),
		.mag      (fr_mag)
	);

	// square root
	logic sq_vld;
	logic [QW-1:0] sq_root;
	logic [SIDE1_W-1:0] sq_side;
	logic [2:0] sq_neg;
	logic [2:0][RW-1:0] sq_mag;
	logic [1:0] sq_kase;

	raq_sqrt #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE1_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (fr_vld),
		.rad      (fr_rad),
		.in_side  ({fr_neg, fr_mag, fr_kase}),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.out_side (sq_side)
	);

	assign {sq_neg, sq_mag, sq_kase} = sq_side;

	// three divisions by s = 2*root
	logic dv_vld;
	logic [2:0] dv_neg;
	logic [2:0][FRAC_BITS:0] dv_quot;
	logic [SIDE2_W-1:0] dv_side;
	logic [QW-1:0] dv_root;
	logic [1:0] dv_kase;

	raq_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE2_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (sq_vld),
		.divisor  ({sq_root, 1'b0}),
		.in_neg   (sq_neg),
		.in_mag   (sq_mag),
		.in_side  ({sq_root, sq_kase}),
		.out_vld  (dv_vld),
		.out_neg  (dv_neg),
		.quot     (dv_quot),
		.out_side (dv_side)
	);

	assign {dv_root, dv_kase} = dv_side;

	// put the diagonal part and the three quotients in place
	fx_t diag_c;
	fx_t v_c [3];
	quat_t res_c;

	always_comb begin
		diag_c = DATA_W'(dv_root >> 1);
		for (int j = 0; j < 3; j++) begin
			v_c[j] = dv_neg[j] ? -DATA_W'(dv_quot[j]) : DATA_W'(dv_quot[j]);
		end
		res_c.case_taken = dv_kase;
		unique case (case_t'(dv_kase))
			CASE_TRACE: begin
				res_c.q_w = diag_c;
				res_c.q_x = v_c[0];
				res_c.q_y = v_c[1];
				res_c.q_z = v_c[2];
			end
			CASE_M00: begin
				res_c.q_w = v_c[0];
				res_c.q_x = diag_c;
				res_c.q_y = v_c[1];
				res_c.q_z = v_c[2];
			end
			CASE_M11: begin
				res_c.q_w = v_c[0];
				res_c.q_x = v_c[1];
				res_c.q_y = diag_c;
				res_c.q_z = v_c[2];
			end
			CASE_M22: begin
				res_c.q_w = v_c[0];
				res_c.q_x = v_c[1];
				res_c.q_y = v_c[2];
				res_c.q_z = diag_c;
			end
			default: begin
				res_c.q_w = diag_c;
				res_c.q_x = v_c[0];
				res_c.q_y = v_c[1];
				res_c.q_z = v_c[2];
			end
		endcase
	end

	// output register plus spare entry
	logic out_vld_q, spare_vld_q;
	quat_t out_q, spare_q;
	logic take, push;

	assign en   = !spare_vld_q;
	assign take = out_vld_q && quat.ready;
	assign push = en && dv_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			spare_vld_q <= 1'b0;
		end else if (take) begin
			if (spare_vld_q) begin
				spare_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			if (!out_vld_q) begin
				out_vld_q <= 1'b1;
			end else begin
				spare_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && spare_vld_q) begin
			out_q <= spare_q;
		end else if (push && (take || !out_vld_q)) begin
			out_q <= res_c;
		end else if (push) begin
			spare_q <= res_c;
		end
	end

	assign axes.ready = en;
	assign quat.valid = out_vld_q;
	assign quat.data  = out_q;

	a_spare_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		spare_vld_q |-> out_vld_q)
		else $error("spare entry full while output entry empty");

	a_spare_holds: assert property (@(posedge clk) disable iff (!arst_n)
		spare_vld_q && !quat.ready |=> spare_vld_q && $stable(spare_q))
		else $error("spare entry changed while output stalled");

	a_qw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_q.q_w <= ONE_32) && (out_q.q_w >= -ONE_32))
		else $error("q_w outside plus or minus one");

endmodule
`default_nettype wire
